// File: sv/pip_pkg.sv
// Shared types and constants for the point-in-polygon test unit.
`timescale 1ns / 1ps
package pip_pkg;

	// Polygon store capacity and derived widths
	localparam int MAX_VERTICES = 64;
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	// Command codes
	localparam logic CMD_VERTEX = 1'b0;
	localparam logic CMD_TEST   = 1'b1;

	typedef logic signed [15:0] coord_t;
	typedef logic [AW-1:0] vaddr_t;
	typedef logic [CW-1:0] vcount_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vertex_t;

	// Sequencer to edge evaluator control
	typedef struct packed {
		logic clear;
		logic valid;
		logic first;
	} eval_ctl_t;

endpackage

// File: sv/pip_if.sv
// Command and result channel interfaces for the point-in-polygon test unit.
`timescale 1ns / 1ps
interface pip_cmd_if;
	import pip_pkg::*;
	logic   valid;
	logic   ready;
	logic   command;
	logic   start_new;
	coord_t coord_x;
	coord_t coord_y;
	modport source (output valid, command, start_new, coord_x, coord_y, input ready);
	modport sink (input valid, command, start_new, coord_x, coord_y, output ready);
endinterface

interface pip_res_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic truncated;
	modport source (output valid, inside_res, truncated, input ready);
	modport sink (input valid, inside_res, truncated, output ready);
endinterface

// File: sv/pip_vertex_mem.sv
// Vertex store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module pip_vertex_mem (
	input  logic             clk,
	input  logic             we,
	input  pip_pkg::vaddr_t  waddr,
	input  pip_pkg::vertex_t wdata,
	input  logic             re,
	input  pip_pkg::vaddr_t  raddr,
	output pip_pkg::vertex_t rdata
);
	import pip_pkg::*;

	vertex_t mem [MAX_VERTICES];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/pip_edge_eval.sv
// Edge evaluator: pipelined straddle test and exact cross-multiplied compare.
`timescale 1ns / 1ps
module pip_edge_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  pip_pkg::eval_ctl_t ctl,
	input  pip_pkg::vertex_t   rdata,
	input  pip_pkg::coord_t    px,
	input  pip_pkg::coord_t    py,
	output logic               parity,
	output logic               busy
);
	import pip_pkg::*;

	vertex_t            prev_q;
	logic               v_s1;
	logic               straddle_s1;
	logic               neg_s1;
	logic signed [16:0] dy_s1, dpx_s1, dxb_s1, dpy_s1;
	logic               v_s2;
	logic               neg_s2;
	logic signed [33:0] lhs_s2, rhs_s2;
	logic               parity_q;
	logic               straddle;
	logic signed [16:0] dy;
	logic               toggle;

	// a = current vertex (read data), b = previous vertex
	assign straddle = (rdata.y > py) != (prev_q.y > py);
	assign dy = $signed({prev_q.y[15], prev_q.y}) - $signed({rdata.y[15], rdata.y});

	// compare flips sense when the edge's y span is negative
	assign toggle = v_s2 && (neg_s2 ? (lhs_s2 > rhs_s2) : (lhs_s2 < rhs_s2));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			parity_q <= 1'b0;
		end else begin
			v_s1 <= ctl.valid && !ctl.first;
			v_s2 <= v_s1 && straddle_s1;
			if (ctl.clear) begin
				parity_q <= 1'b0;
			end else if (toggle) begin
				parity_q <= !parity_q;
			end
		end
	end

	// datapath: differences, then products
	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			prev_q <= rdata;
		end
		straddle_s1 <= straddle;
		neg_s1      <= dy[16];
		dy_s1       <= dy;
		dpx_s1      <= $signed({px[15], px}) - $signed({rdata.x[15], rdata.x});
		dxb_s1      <= $signed({prev_q.x[15], prev_q.x}) - $signed({rdata.x[15], rdata.x});
		dpy_s1      <= $signed({py[15], py}) - $signed({rdata.y[15], rdata.y});
		lhs_s2      <= 34'(dpx_s1) * 34'(dy_s1);
		rhs_s2      <= 34'(dxb_s1) * 34'(dpy_s1);
		neg_s2      <= neg_s1;
	end

	assign parity = parity_q;
	assign busy   = v_s1 || v_s2;

endmodule

// File: sv/point_in_polygon_test_unit.sv
// Top level of the even-odd point-in-polygon test unit.
//
// Usage: words arrive on the cmd channel (valid/ready). A vertex word
// (command 0) appends a corner to the stored polygon, after emptying it when
// start_new is set; it gives no result. Corners beyond
// the store capacity are dropped and remembered in the truncated flag.
// A test word (command 1) walks every stored edge, last corner to first and
// then each consecutive pair, and delivers one word on the res channel with
// inside_res and truncated. A test with n stored corners takes n + 1 reads
// of the vertex memory, one per cycle, then passes through the registered
// read, the two-stage multiply/compare pipeline and the output register
// before the sequencer returns to idle; the single read port of the vertex
// memory sets the pace of the walk. cmd is not accepted while a test walks.
// A finished result waits in the output register; when the receiver stalls,
// vertex words are still taken, and a following test holds its result until
// the register frees up.
// Reset empties the polygon and clears the truncated flag and output valid.
`timescale 1ns / 1ps
module point_in_polygon_test_unit (
	input  logic clk,
	input  logic arst_n,
	pip_cmd_if.sink   cmd,
	pip_res_if.source res
);
	import pip_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t    state_q;
	vcount_t   count_q;
	logic      overflow_q;
	logic      first_q;
	vaddr_t    rd_idx_q;
	vaddr_t    last_addr_q;
	coord_t    px_q, py_q;
	logic      rvalid_s1, rfirst_s1;
	logic      out_valid_q, inside_q, trunc_q;

	logic      accept, is_test, room, we, rd_en, eval_busy, parity, done;
	vcount_t   wr_idx;
	vaddr_t    rd_addr;
	vertex_t   wdata, rdata;
	eval_ctl_t ctl;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign is_test   = (cmd.command == CMD_TEST);

	// vertex append
	assign wr_idx  = cmd.start_new ? '0 : count_q;
	assign room    = cmd.start_new || (count_q < vcount_t'(MAX_VERTICES));
	assign we      = accept && !is_test && room;
	assign wdata.x = cmd.coord_x;
	assign wdata.y = cmd.coord_y;

	// edge walk reads: previous (last) corner first, then 0 .. n-1
	assign rd_en   = (state_q == ST_WALK);
	assign rd_addr = first_q ? last_addr_q : rd_idx_q;

	assign ctl.clear = accept && is_test;
	assign ctl.valid = rvalid_s1;
	assign ctl.first = rfirst_s1;

	assign done = (state_q == ST_DRAIN) && !rvalid_s1 && !eval_busy
		&& (!out_valid_q || res.ready);

	pip_vertex_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (wr_idx[AW-1:0]),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	pip_edge_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rdata  (rdata),
		.px     (px_q),
		.py     (py_q),
		.parity (parity),
		.busy   (eval_busy)
	);

	// sequencer and polygon bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			overflow_q <= 1'b0;
			first_q    <= 1'b0;
			rd_idx_q   <= '0;
			rvalid_s1  <= 1'b0;
			rfirst_s1  <= 1'b0;
		end else begin
			rvalid_s1 <= rd_en;
			rfirst_s1 <= rd_en && first_q;
			case (state_q)
				ST_IDLE: begin
					if (accept && !is_test) begin
						if (room) begin
							count_q <= wr_idx + vcount_t'(1);
						end
						if (cmd.start_new) begin
							overflow_q <= 1'b0;
						end else if (!room) begin
							overflow_q <= 1'b1;
						end
					end else if (accept) begin
						first_q  <= 1'b1;
						rd_idx_q <= '0;
						state_q  <= (count_q == '0) ? ST_DRAIN : ST_WALK;
					end
				end
				ST_WALK: begin
					if (first_q) begin
						first_q <= 1'b0;
					end else if (rd_idx_q == last_addr_q) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + vaddr_t'(1);
					end
				end
				ST_DRAIN: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// test point and walk bound
	always_ff @(posedge clk) begin
		if (accept && is_test) begin
			px_q        <= cmd.coord_x;
			py_q        <= cmd.coord_y;
			last_addr_q <= AW'(count_q - vcount_t'(1));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			inside_q <= parity;
			trunc_q  <= overflow_q;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.inside_res = inside_q;
	assign res.truncated  = trunc_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= vcount_t'(MAX_VERTICES))
		else $error("vertex count above capacity");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> (count_q == vcount_t'(MAX_VERTICES)))
		else $error("truncated flag set with room left in store");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (CW'(rd_addr) < count_q))
		else $error("edge walk reads beyond stored corners");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rvalid_s1 && !eval_busy))
		else $error("edge pipeline busy while idle");

endmodule
